// ===== rtl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, character codes and a helper function for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int VALUE_W    = 64;
    localparam int DIV_SLICE  = 8;
    localparam int RESULT_CAP = 63;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_DIGIT,
        S_PREC,
        S_WID,
        S_TRIM1,
        S_TRIM2,
        S_PFX,
        S_PFX0,
        S_SIGN,
        S_EMIT_INIT,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_DIGIT,
        OP_ZERO,
        OP_PFX,
        OP_POP,
        OP_SIGN,
        OP_EMIT_INIT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic skip_digits;
        logic is_dec;
        logic div_last;
        logic digit_more;
        logic left;
        logic hash;
        logic need_prec;
        logic need_wid;
        logic trim1;
        logic trim2;
        logic pfx_needed;
        logic not_full;
        logic sign_needed;
        logic emit_done;
        logic emit_last;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + d8;
        end else begin
            digit_char = (upper ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/ita_ctrl.sv =====
// ----------------------------------------------------------------------------
// ita_ctrl
// Sequencer that walks one number through digit generation, padding,
// prefix, sign and character output.
// ----------------------------------------------------------------------------
module ita_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ita_pkg::stat_t   stat,
    output ita_pkg::op_t     op
);

    ita_pkg::state_t state_reg;
    ita_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ita_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ita_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ita_pkg::S_START;
                end
            end
            ita_pkg::S_START:
            begin
                if (stat.skip_digits)
                begin
                    state_next = ita_pkg::S_PREC;
                end
                else if (stat.is_dec)
                begin
                    state_next = ita_pkg::S_DIV;
                end
                else
                begin
                    state_next = ita_pkg::S_DIGIT;
                end
            end
            ita_pkg::S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ita_pkg::S_DIGIT;
                end
            end
            ita_pkg::S_DIGIT:
            begin
                if (!stat.digit_more)
                begin
                    state_next = ita_pkg::S_PREC;
                end
                else if (stat.is_dec)
                begin
                    state_next = ita_pkg::S_DIV;
                end
            end
            ita_pkg::S_PREC:
            begin
                if (stat.left || !stat.need_prec)
                begin
                    state_next = ita_pkg::S_WID;
                end
            end
            ita_pkg::S_WID:
            begin
                if (stat.left || !stat.need_wid)
                begin
                    state_next = ita_pkg::S_TRIM1;
                end
            end
            ita_pkg::S_TRIM1:
            begin
                if (!stat.hash)
                begin
                    state_next = ita_pkg::S_SIGN;
                end
                else if (stat.trim1)
                begin
                    state_next = ita_pkg::S_TRIM2;
                end
                else
                begin
                    state_next = ita_pkg::S_PFX;
                end
            end
            ita_pkg::S_TRIM2:
            begin
                state_next = ita_pkg::S_PFX;
            end
            ita_pkg::S_PFX:
            begin
                state_next = ita_pkg::S_PFX0;
            end
            ita_pkg::S_PFX0:
            begin
                state_next = ita_pkg::S_SIGN;
            end
            ita_pkg::S_SIGN:
            begin
                state_next = ita_pkg::S_EMIT_INIT;
            end
            ita_pkg::S_EMIT_INIT:
            begin
                state_next = ita_pkg::S_EMIT;
            end
            ita_pkg::S_EMIT:
            begin
                if (stat.emit_done || (stat.out_free && stat.emit_last))
                begin
                    state_next = ita_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ita_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op       = ita_pkg::OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            ita_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = ita_pkg::OP_LOAD;
                end
            end
            ita_pkg::S_DIV:
            begin
                op = ita_pkg::OP_DIV;
            end
            ita_pkg::S_DIGIT:
            begin
                op = ita_pkg::OP_DIGIT;
            end
            ita_pkg::S_PREC:
            begin
                if (!stat.left && stat.need_prec)
                begin
                    op = ita_pkg::OP_ZERO;
                end
            end
            ita_pkg::S_WID:
            begin
                if (!stat.left && stat.need_wid)
                begin
                    op = ita_pkg::OP_ZERO;
                end
            end
            ita_pkg::S_TRIM1:
            begin
                if (stat.hash && stat.trim1)
                begin
                    op = ita_pkg::OP_POP;
                end
            end
            ita_pkg::S_TRIM2:
            begin
                if (stat.trim2)
                begin
                    op = ita_pkg::OP_POP;
                end
            end
            ita_pkg::S_PFX:
            begin
                if (stat.pfx_needed)
                begin
                    op = ita_pkg::OP_PFX;
                end
            end
            ita_pkg::S_PFX0:
            begin
                if (stat.not_full)
                begin
                    op = ita_pkg::OP_ZERO;
                end
            end
            ita_pkg::S_SIGN:
            begin
                if (stat.sign_needed)
                begin
                    op = ita_pkg::OP_SIGN;
                end
            end
            ita_pkg::S_EMIT_INIT:
            begin
                op = ita_pkg::OP_EMIT_INIT;
            end
            ita_pkg::S_EMIT:
            begin
                if (!stat.emit_done && stat.out_free)
                begin
                    op = ita_pkg::OP_EMIT;
                end
            end
            default:
            begin
                op = ita_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/ita_datapath.sv =====
// ----------------------------------------------------------------------------
// ita_datapath
// Operand registers, divide-by-ten slice unit, character stack and the
// output register of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
module ita_datapath #(
    parameter int DIGIT_BUFFER = 32,
    parameter int MAX_FIELD    = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ita_pkg::op_t                  op,
    input  logic [ita_pkg::VALUE_W-1:0]   value,
    input  logic                          negative,
    input  logic [1:0]                    base_select,
    input  logic [5:0]                    precision,
    input  logic [5:0]                    width,
    input  logic                          zero_pad,
    input  logic                          left_justify,
    input  logic                          plus_sign,
    input  logic                          space_sign,
    input  logic                          alt_form,
    input  logic                          upper_case,
    input  logic                          precision_given,
    output ita_pkg::stat_t                stat,
    output logic [7:0]                    char_out,
    output logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int VW        = ita_pkg::VALUE_W;
    localparam int LW        = $clog2(DIGIT_BUFFER + 1);
    localparam int EW        = (LW > 6) ? LW : 6;
    localparam int DIV_STEPS = ita_pkg::VALUE_W / ita_pkg::DIV_SLICE;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam logic [5:0]     MAX_F    = 6'(MAX_FIELD);
    localparam logic [LW-1:0]  LEN_FULL = LW'(DIGIT_BUFFER);
    localparam logic [EW-1:0]  CAP      = EW'(ita_pkg::RESULT_CAP);
    localparam logic [DCW-1:0] DIV_END  = DCW'(DIV_STEPS - 1);

    logic [VW-1:0]  w_reg, w_next;
    logic [3:0]     rem_reg, rem_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [1:0]     base_reg, base_next;
    logic [5:0]     prec_reg, prec_next;
    logic [5:0]     wid_reg, wid_next;
    logic           zpad_reg, zpad_next;
    logic           left_reg, left_next;
    logic           neg_reg, neg_next;
    logic           plus_reg, plus_next;
    logic           space_reg, space_next;
    logic           hash_reg, hash_next;
    logic           upper_reg, upper_next;
    logic           pgiven_reg, pgiven_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [7:0]     stack_reg [DIGIT_BUFFER];
    logic [7:0]     stack_next [DIGIT_BUFFER];
    logic [EW-1:0]  cnt_reg, cnt_next;
    logic [EW-1:0]  lp_reg, lp_next;
    logic [EW-1:0]  emit_rem_reg, emit_rem_next;
    logic [7:0]     char_reg, char_next;
    logic           last_reg, last_next;
    logic           ovalid_reg, ovalid_next;

    logic [5:0]     prec_sat, wid_sat, wid_load;
    logic [3:0]     div_r;
    logic [VW-1:0]  div_w;
    logic [4:0]     div_t;
    logic [2:0]     shamt;
    logic [3:0]     dig_mask;
    logic [3:0]     dig;
    logic [VW-1:0]  w_shift;
    logic           next_zero;
    logic           is_dec, is_hex, is_bin;
    logic           full;
    logic [EW-1:0]  len_ext, wid_ext, prec_ext, wid_max, total;
    logic           do_push, do_pop;
    logic [7:0]     push_char;
    logic [7:0]     emit_char;

    assign prec_sat = (precision > MAX_F) ? MAX_F : precision;
    assign wid_sat  = (width > MAX_F) ? MAX_F : width;
    assign wid_load = (wid_sat != 6'd0 && zero_pad && !left_justify
                       && (negative || plus_sign || space_sign)) ? wid_sat - 6'd1 : wid_sat;

    assign is_dec = (base_reg == ita_pkg::BASE_DEC);
    assign is_hex = (base_reg == ita_pkg::BASE_HEX);
    assign is_bin = (base_reg == ita_pkg::BASE_BIN);

    always_comb
    begin
        div_r = (div_cnt_reg == '0) ? 4'd0 : rem_reg;
        div_w = w_reg;
        div_t = 5'd0;
        for (int k = 0; k < ita_pkg::DIV_SLICE; k++)
        begin
            div_t = {div_r, div_w[VW-1]};
            div_w = {div_w[VW-2:0], (div_t >= 5'd10)};
            div_r = (div_t >= 5'd10) ? 4'(div_t - 5'd10) : div_t[3:0];
        end
    end

    always_comb
    begin
        case (base_reg)
            ita_pkg::BASE_HEX:
            begin
                shamt    = 3'd4;
                dig_mask = 4'hf;
            end
            ita_pkg::BASE_OCT:
            begin
                shamt    = 3'd3;
                dig_mask = 4'h7;
            end
            ita_pkg::BASE_BIN:
            begin
                shamt    = 3'd1;
                dig_mask = 4'h1;
            end
            default:
            begin
                shamt    = 3'd0;
                dig_mask = 4'hf;
            end
        endcase
    end

    assign w_shift   = w_reg >> shamt;
    assign dig       = is_dec ? rem_reg : (w_reg[3:0] & dig_mask);
    assign next_zero = is_dec ? (w_reg == '0) : (w_shift == '0);
    assign full      = (len_reg == LEN_FULL);

    assign len_ext  = EW'(len_reg);
    assign wid_ext  = EW'(wid_reg);
    assign prec_ext = EW'(prec_reg);
    assign wid_max  = (wid_ext > len_ext) ? wid_ext : len_ext;
    assign total    = (!left_reg && zpad_reg) ? len_ext : wid_max;

    assign emit_char = (cnt_reg < lp_reg) ? ita_pkg::CH_SPACE
                     : ((len_reg != '0) ? stack_reg[0] : ita_pkg::CH_SPACE);

    always_comb
    begin
        w_next        = w_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        base_next     = base_reg;
        prec_next     = prec_reg;
        wid_next      = wid_reg;
        zpad_next     = zpad_reg;
        left_next     = left_reg;
        neg_next      = neg_reg;
        plus_next     = plus_reg;
        space_next    = space_reg;
        hash_next     = hash_reg;
        upper_next    = upper_reg;
        pgiven_next   = pgiven_reg;
        cnt_next      = cnt_reg;
        lp_next       = lp_reg;
        emit_rem_next = emit_rem_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        do_push       = 1'b0;
        do_pop        = 1'b0;
        push_char     = ita_pkg::CH_ZERO;

        case (op)
            ita_pkg::OP_LOAD:
            begin
                w_next       = value;
                div_cnt_next = '0;
                base_next    = base_select;
                prec_next    = prec_sat;
                wid_next     = wid_load;
                zpad_next    = zero_pad;
                left_next    = left_justify;
                neg_next     = negative;
                plus_next    = plus_sign;
                space_next   = space_sign;
                hash_next    = alt_form && (value != '0);
                upper_next   = upper_case;
                pgiven_next  = precision_given;
            end
            ita_pkg::OP_DIV:
            begin
                w_next       = div_w;
                rem_next     = div_r;
                div_cnt_next = div_cnt_reg + DCW'(1);
            end
            ita_pkg::OP_DIGIT:
            begin
                do_push   = 1'b1;
                push_char = ita_pkg::digit_char(dig, upper_reg);
                if (!is_dec)
                begin
                    w_next = w_shift;
                end
            end
            ita_pkg::OP_ZERO:
            begin
                do_push   = 1'b1;
                push_char = ita_pkg::CH_ZERO;
            end
            ita_pkg::OP_PFX:
            begin
                do_push   = 1'b1;
                push_char = is_hex ? (upper_reg ? ita_pkg::CH_X_UP : ita_pkg::CH_X_LO)
                                   : ita_pkg::CH_B;
            end
            ita_pkg::OP_SIGN:
            begin
                do_push   = 1'b1;
                push_char = neg_reg ? ita_pkg::CH_MINUS
                          : (plus_reg ? ita_pkg::CH_PLUS : ita_pkg::CH_SPACE);
            end
            ita_pkg::OP_POP:
            begin
                do_pop = 1'b1;
            end
            ita_pkg::OP_EMIT_INIT:
            begin
                cnt_next      = '0;
                emit_rem_next = (total > CAP) ? CAP : total;
                lp_next       = (!left_reg && !zpad_reg && wid_ext > len_ext)
                              ? wid_ext - len_ext : '0;
            end
            ita_pkg::OP_EMIT:
            begin
                char_next     = emit_char;
                last_next     = (emit_rem_reg == EW'(1));
                ovalid_next   = 1'b1;
                cnt_next      = cnt_reg + EW'(1);
                emit_rem_next = emit_rem_reg - EW'(1);
                do_pop        = (cnt_reg >= lp_reg) && (len_reg != '0);
            end
            default:
            begin
                do_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        for (int i = 0; i < DIGIT_BUFFER; i++)
        begin
            stack_next[i] = stack_reg[i];
        end
        if (do_push)
        begin
            len_next      = len_reg + LW'(1);
            stack_next[0] = push_char;
            for (int i = 1; i < DIGIT_BUFFER; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
        end
        else if (do_pop)
        begin
            len_next = len_reg - LW'(1);
            for (int i = 0; i < DIGIT_BUFFER - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            div_cnt_reg  <= '0;
            cnt_reg      <= '0;
            emit_rem_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            div_cnt_reg  <= div_cnt_next;
            cnt_reg      <= cnt_next;
            emit_rem_reg <= emit_rem_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        prec_reg   <= prec_next;
        wid_reg    <= wid_next;
        zpad_reg   <= zpad_next;
        left_reg   <= left_next;
        neg_reg    <= neg_next;
        plus_reg   <= plus_next;
        space_reg  <= space_next;
        hash_reg   <= hash_next;
        upper_reg  <= upper_next;
        pgiven_reg <= pgiven_next;
        lp_reg     <= lp_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        for (int i = 0; i < DIGIT_BUFFER; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
    end

    always_comb
    begin
        stat.skip_digits = pgiven_reg && (w_reg == '0);
        stat.is_dec      = is_dec;
        stat.div_last    = (div_cnt_reg == DIV_END);
        stat.digit_more  = !next_zero && ((len_reg + LW'(1)) != LEN_FULL);
        stat.left        = left_reg;
        stat.hash        = hash_reg;
        stat.need_prec   = (len_ext < prec_ext) && !full;
        stat.need_wid    = zpad_reg && (len_ext < wid_ext) && !full;
        stat.trim1       = !pgiven_reg && (len_reg != '0)
                           && ((len_ext == prec_ext) || (len_ext == wid_ext));
        stat.trim2       = (len_reg != '0) && is_hex;
        stat.pfx_needed  = (is_hex || is_bin) && !full;
        stat.not_full    = !full;
        stat.sign_needed = (neg_reg || plus_reg || space_reg) && !full;
        stat.emit_done   = (emit_rem_reg == '0);
        stat.emit_last   = (emit_rem_reg == EW'(1));
        stat.out_free    = !ovalid_reg || out_ready;
    end

    assign char_out  = char_reg;
    assign last      = last_reg;
    assign out_valid = ovalid_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("Character stack count exceeds the buffer depth.");

    a_emit_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
        op == ita_pkg::OP_EMIT |-> emit_rem_reg != '0)
        else $error("Character emitted with no characters left.");
`endif

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one unsigned 64-bit magnitude with a sign mark as a printf-style
// integer field and sends it out one ASCII character per item.
// ----------------------------------------------------------------------------
// One number is handled at a time. After loading, the start state chooses
// the digit path. A decimal digit passes through the divide-by-ten unit,
// which retires eight quotient bits per cycle, and is then stored; a hex,
// octal or binary digit is stored straight from the shifted value.
// Zero padding follows, then the trim, prefix and sign steps, the trim and
// prefix ones only with the alternate form. The field then leaves through a
// single output register at one character per cycle while out_ready is high,
// at most 63 of them.
// A number may produce no characters at all; last marks the final one.
module integer_to_ascii_formatter #(
    parameter int DIGIT_BUFFER = 32,
    parameter int MAX_FIELD    = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic        negative,
    input  logic [1:0]  base_select,
    input  logic [5:0]  precision,
    input  logic [5:0]  width,
    input  logic        zero_pad,
    input  logic        left_justify,
    input  logic        plus_sign,
    input  logic        space_sign,
    input  logic        alt_form,
    input  logic        upper_case,
    input  logic        precision_given,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic        last
);

    ita_pkg::op_t   op;
    ita_pkg::stat_t stat;

    ita_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    ita_datapath #(
        .DIGIT_BUFFER (DIGIT_BUFFER),
        .MAX_FIELD    (MAX_FIELD)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .value           (value),
        .negative        (negative),
        .base_select     (base_select),
        .precision       (precision),
        .width           (width),
        .zero_pad        (zero_pad),
        .left_justify    (left_justify),
        .plus_sign       (plus_sign),
        .space_sign      (space_sign),
        .alt_form        (alt_form),
        .upper_case      (upper_case),
        .precision_given (precision_given),
        .stat            (stat),
        .char_out        (char_out),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A new item was taken while the previous one was in work.");

    a_no_gap_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("Gap inside a formatted field.");

    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("Ready for input while a field is still being sent.");
`endif

endmodule
